/* rtl/core/linear_probe_hash_table_core_defines.svh */
// ----------------------------------------------------------------------------
// linear probe hash table defines
// assertion macros used by the checker, sampled on i_clk, off in reset
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lpht check failed: same-cycle rule");

// next-cycle implication
`define LPHT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lpht check failed: next-cycle rule");

`endif

/* rtl/core/lpht_pkg.sv */
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and fixed constants of the linear probe hash table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int MODE_W              = 2;
    localparam int STATUS_W            = 2;
    localparam int MARK_W              = 2;
    localparam int LIVE_COUNT_W        = 11;
    // key bits folded into the remainder per cycle when the depth is not a power of two
    localparam int HASH_BITS_PER_CYCLE = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD,
        MODE_REMOVE,
        MODE_FIND,
        MODE_CHANGE
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_NOT_FOUND,
        ST_PRESENT,
        ST_FULL
    } t_status;

    typedef enum logic [MARK_W-1:0] {
        MARK_EMPTY,
        MARK_LIVE,
        MARK_DELETED
    } t_mark;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_ISSUE,
        S_PROBE,
        S_APPLY
    } t_state;

endpackage

/* rtl/core/linear_probe_hash_table_core.sv */
// ----------------------------------------------------------------------------
// linear probe hash table core
// open-addressing key/value table, linear probing with tombstones
// ----------------------------------------------------------------------------
// usage
//   request channel: i_in_valid / o_in_ready with i_mode, i_key, i_value
//   (add, remove, find, change value). result channel: o_out_valid /
//   i_out_ready with o_status, o_found_value, o_live_count, one per request.
//   one request is worked on at a time; o_in_ready is high only when idle.
//   a probe starts at key mod TABLE_DEPTH and reads one slot per cycle from
//   the single read port of the slot memories; once the walk stops the
//   result is committed in the apply state, and the next request is taken
//   once the sequencer is back in idle. when TABLE_DEPTH is not a power of
//   two the home slot comes from a remainder unit before the first read.
//   after reset the slot marks are cleared one slot per cycle, and no
//   request is taken meanwhile.
//   the result sits in an output register; a stalled receiver holds it there
//   while the next request is accepted and probed, and that request only
//   commits once the register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module linear_probe_hash_table_core
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [KEY_WIDTH-1:0]    i_key,
    input  logic [VALUE_WIDTH-1:0]  i_value,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [STATUS_W-1:0]     o_status,
    output logic [VALUE_WIDTH-1:0]  o_found_value,
    output logic [LIVE_COUNT_W-1:0] o_live_count
);

    // ------------------------------------------------------------------
    // derived sizes
    // ------------------------------------------------------------------
    localparam int       AW       = $clog2(TABLE_DEPTH);
    localparam bit       IS_POW2  = (TABLE_DEPTH == (1 << AW));
    localparam int       HALF     = TABLE_DEPTH / 2;
    localparam int       CW       = $clog2(HALF + 1);
    localparam int       KPAD     = ((KEY_WIDTH + HASH_BITS_PER_CYCLE - 1)
                                     / HASH_BITS_PER_CYCLE) * HASH_BITS_PER_CYCLE;
    localparam int       HASH_CYC = KPAD / HASH_BITS_PER_CYCLE;
    localparam int       HCW      = $clog2(HASH_CYC);
    localparam int       KXW      = (KEY_WIDTH > AW) ? KEY_WIDTH : AW;
    localparam [AW-1:0]  LAST     = AW'(TABLE_DEPTH - 1);

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state                 r_state, n_state;
    logic [AW-1:0]          r_clr_addr;

    // latched request
    t_mode                  r_mode;
    logic [KEY_WIDTH-1:0]   r_key;
    logic [VALUE_WIDTH-1:0] r_value;

    // remainder unit
    logic [KPAD-1:0]        r_key_sh;
    logic [AW-1:0]          r_rem, n_rem;
    logic [HCW-1:0]         r_hcnt;

    // probe walk
    logic [AW-1:0]          r_chk_addr;
    logic [AW:0]            r_cnt;
    logic                   r_hit;
    logic [AW-1:0]          r_hit_addr;
    logic [VALUE_WIDTH-1:0] r_found;
    logic                   r_free_ok;
    logic                   r_free_del;
    logic [AW-1:0]          r_free_addr;

    // occupancy counters
    logic [CW-1:0]          r_live, n_live;
    logic [CW-1:0]          r_deleted, n_deleted;

    // result register
    logic                   r_out_valid;
    t_status                r_status;
    logic [VALUE_WIDTH-1:0] r_out_found;

    // slot memories, one write and one registered read per cycle
    logic [MARK_W-1:0]      mark_mem [TABLE_DEPTH];
    logic [KEY_WIDTH-1:0]   key_mem  [TABLE_DEPTH];
    logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
    logic [MARK_W-1:0]      r_rd_mark;
    logic [KEY_WIDTH-1:0]   r_rd_key;
    logic [VALUE_WIDTH-1:0] r_rd_val;

    // combinational
    logic                   accept;
    logic [KXW-1:0]         key_ext;
    logic [AW-1:0]          home;
    logic [AW-1:0]          addr_next;
    logic [AW-1:0]          rd_addr;
    logic                   rd_live;
    logic                   rd_empty;
    logic                   rd_match;
    logic                   last_slot;
    logic                   probe_done;
    logic                   out_free;
    logic [CW:0]            occ_sum;
    logic                   at_half;
    logic                   do_add;
    logic                   do_remove;
    logic                   do_change;
    t_status                apply_status;
    logic [VALUE_WIDTH-1:0] apply_found;
    logic                   commit;
    logic                   mark_we;
    logic [AW-1:0]          mark_wa;
    t_mark                  mark_wd;
    logic                   key_we;
    logic                   val_we;
    logic [AW-1:0]          val_wa;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign commit   = (r_state == S_APPLY) && out_free;

    // ------------------------------------------------------------------
    // home slot: a mask for power-of-two depths, else the remainder unit
    // ------------------------------------------------------------------
    assign key_ext = KXW'(r_key);
    assign home    = IS_POW2 ? key_ext[AW-1:0] : r_rem;

    // restoring remainder, a few key bits per cycle, msb first
    always_comb begin : hash_step
        logic [AW:0]   t;
        logic [AW-1:0] rem;
        rem = r_rem;
        for (int j = 0; j < HASH_BITS_PER_CYCLE; j++) begin
            t = {rem, r_key_sh[KPAD-1-j]};
            if (t >= (AW+1)'(TABLE_DEPTH)) begin
                t = t - (AW+1)'(TABLE_DEPTH);
            end
            rem = t[AW-1:0];
        end
        n_rem = rem;
    end

    // ------------------------------------------------------------------
    // probe evaluation on the slot read last cycle
    // ------------------------------------------------------------------
    assign addr_next  = (r_chk_addr == LAST) ? '0 : r_chk_addr + AW'(1);
    assign rd_live    = (r_rd_mark == MARK_LIVE);
    assign rd_empty   = (r_rd_mark == MARK_EMPTY);
    assign rd_match   = rd_live && (r_rd_key == r_key);
    // the whole table has been walked once
    assign last_slot  = (r_cnt == (AW+1)'(TABLE_DEPTH - 1));
    assign probe_done = rd_empty || rd_match || last_slot;

    // ------------------------------------------------------------------
    // commit decision
    // ------------------------------------------------------------------
    assign occ_sum = {1'b0, r_live} + {1'b0, r_deleted};
    assign at_half = (occ_sum >= (CW+1)'(HALF));

    always_comb begin
        apply_status = ST_OK;
        apply_found  = '0;
        do_add       = 1'b0;
        do_remove    = 1'b0;
        do_change    = 1'b0;
        unique case (r_mode)
            MODE_ADD: begin
                priority if (r_hit) begin
                    apply_status = ST_PRESENT;
                end else if (at_half || !r_free_ok) begin
                    apply_status = ST_FULL;
                end else begin
                    do_add = 1'b1;
                end
            end
            MODE_REMOVE: begin
                if (r_hit) begin
                    do_remove = 1'b1;
                end else begin
                    apply_status = ST_NOT_FOUND;
                end
            end
            MODE_FIND: begin
                if (r_hit) begin
                    apply_found = r_found;
                end else begin
                    apply_status = ST_NOT_FOUND;
                end
            end
            MODE_CHANGE: begin
                if (r_hit) begin
                    do_change = 1'b1;
                end else begin
                    apply_status = ST_NOT_FOUND;
                end
            end
            default: begin
                apply_status = ST_NOT_FOUND;
            end
        endcase
    end

    // occupancy after the request; a reused tombstone moves from deleted to live
    always_comb begin
        n_live    = r_live;
        n_deleted = r_deleted;
        if (do_add) begin
            n_live = r_live + CW'(1);
            if (r_free_del && (r_deleted != '0)) begin
                n_deleted = r_deleted - CW'(1);
            end
        end
        if (do_remove) begin
            if (r_live != '0) begin
                n_live = r_live - CW'(1);
            end
            n_deleted = r_deleted + CW'(1);
        end
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == LAST) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = IS_POW2 ? S_ISSUE : S_HASH;
            end
            S_HASH: begin
                if (r_hcnt == HCW'(HASH_CYC - 1)) n_state = S_ISSUE;
            end
            S_ISSUE: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (probe_done) n_state = S_APPLY;
            end
            S_APPLY: begin
                if (out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs (read address, memory writes, handshake)
    // ------------------------------------------------------------------
    always_comb begin
        o_in_ready = 1'b0;
        rd_addr    = r_chk_addr;
        mark_we    = 1'b0;
        mark_wa    = r_hit_addr;
        mark_wd    = MARK_EMPTY;
        key_we     = 1'b0;
        val_we     = 1'b0;
        val_wa     = r_hit_addr;
        unique case (r_state)
            S_CLEAR: begin
                mark_we = 1'b1;
                mark_wa = r_clr_addr;
                mark_wd = MARK_EMPTY;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_ISSUE: begin
                rd_addr = home;
            end
            S_PROBE: begin
                // speculative read of the next slot; dropped when the walk stops
                rd_addr = addr_next;
            end
            S_APPLY: begin
                if (commit) begin
                    if (do_add) begin
                        mark_we = 1'b1;
                        mark_wa = r_free_addr;
                        mark_wd = MARK_LIVE;
                        key_we  = 1'b1;
                        val_we  = 1'b1;
                        val_wa  = r_free_addr;
                    end
                    if (do_remove) begin
                        mark_we = 1'b1;
                        mark_wa = r_hit_addr;
                        mark_wd = MARK_DELETED;
                    end
                    if (do_change) begin
                        val_we = 1'b1;
                        val_wa = r_hit_addr;
                    end
                end
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_live      <= '0;
            r_deleted   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (commit) begin
                r_live      <= n_live;
                r_deleted   <= n_deleted;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode   <= t_mode'(i_mode);
            r_key    <= i_key;
            r_value  <= i_value;
            r_key_sh <= KPAD'(i_key);
            r_rem    <= '0;
            r_hcnt   <= '0;
        end
        if (r_state == S_HASH) begin
            r_rem    <= n_rem;
            r_key_sh <= {r_key_sh[KPAD-HASH_BITS_PER_CYCLE-1:0],
                         HASH_BITS_PER_CYCLE'(0)};
            r_hcnt   <= r_hcnt + HCW'(1);
        end
        if (r_state == S_ISSUE) begin
            r_chk_addr <= home;
            r_cnt      <= '0;
            r_hit      <= 1'b0;
            r_free_ok  <= 1'b0;
        end
        if (r_state == S_PROBE) begin
            if (rd_match) begin
                r_hit      <= 1'b1;
                r_hit_addr <= r_chk_addr;
                r_found    <= r_rd_val;
            end
            // first slot that is not live is where an add lands
            if (!rd_live && !r_free_ok) begin
                r_free_ok   <= 1'b1;
                r_free_addr <= r_chk_addr;
                r_free_del  <= (r_rd_mark == MARK_DELETED);
            end
            if (!probe_done) begin
                r_chk_addr <= addr_next;
                r_cnt      <= r_cnt + (AW+1)'(1);
            end
        end
        if (commit) begin
            r_status    <= apply_status;
            r_out_found <= apply_found;
        end
    end

    // ------------------------------------------------------------------
    // slot memories
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mark_we) mark_mem[mark_wa] <= mark_wd;
        r_rd_mark <= mark_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[r_free_addr] <= r_key;
        r_rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (val_we) val_mem[val_wa] <= r_value;
        r_rd_val <= val_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // result ports; r_live only moves when a new result is loaded
    // ------------------------------------------------------------------
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_value = r_out_found;
    assign o_live_count  = LIVE_COUNT_W'(r_live);

endmodule

/* rtl/core/lpht_checker.sv */
// ----------------------------------------------------------------------------
// lpht checker
// port-level assertions on the linear probe hash table, bound to the core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_defines.svh"

module lpht_checker
    import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_in_valid,
    input logic                    o_in_ready,
    input logic [MODE_W-1:0]       i_mode,
    input logic [KEY_WIDTH-1:0]    i_key,
    input logic [VALUE_WIDTH-1:0]  i_value,
    input logic                    o_out_valid,
    input logic                    i_out_ready,
    input logic [STATUS_W-1:0]     o_status,
    input logic [VALUE_WIDTH-1:0]  o_found_value,
    input logic [LIVE_COUNT_W-1:0] o_live_count
);

    localparam int LIVE_BOUND = TABLE_DEPTH / 2;

    // whole payloads, for hold checks
    logic [MODE_W+KEY_WIDTH+VALUE_WIDTH-1:0]        in_word;
    logic [STATUS_W+VALUE_WIDTH+LIVE_COUNT_W-1:0]   out_word;

    assign in_word  = {i_mode, i_key, i_value};
    assign out_word = {o_status, o_found_value, o_live_count};

    // a value is only returned by a successful find
    `LPHT_ASSERT_IMP(a_found_zero, o_out_valid && (o_status != ST_OK), o_found_value == '0)

    // live entries never pass half the depth
    `LPHT_ASSERT_IMP(a_live_bound, o_out_valid, o_live_count <= LIVE_BOUND)

    // one request at a time: busy right after an accept
    `LPHT_ASSERT_NXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // a waiting request holds
    `LPHT_ASSERT_NXT(a_in_hold, i_in_valid && !o_in_ready, i_in_valid && $stable(in_word))

    // a stalled result holds
    `LPHT_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(out_word))

endmodule

bind linear_probe_hash_table_core lpht_checker #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_lpht_checker (.*);
